>>> rtl/rbs_pkg.sv
`timescale 1ns / 1ps
// rbs_pkg: shared types and constants for the ray/box slab intersection core.
// Used by every file under rtl except rbs_chk; depends on nothing.
package rbs_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIR_STEPS  = 31;
  localparam int SLAB_STEPS = 53;
  localparam int LANES      = 3;
  localparam int SLAB_LANES = 6;

  localparam logic [30:0] PAR_EPS    = 31'd1074;
  localparam logic [30:0] MAXD_RESET = 31'd1310720000;

  typedef logic signed [31:0] coord_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [30:0] rem;
    logic [30:0] den;
    logic [52:0] num;
    logic [52:0] quo;
  } div_lane_t;

  // one lane of the bitwise square root
  typedef struct packed {
    logic [62:0] x;
    logic [62:0] r;
  } sqrt_lane_t;

  // geometry that rides along the root and direction divider chains
  typedef struct packed {
    coord_t [2:0]      o;
    coord_t [2:0]      bmin;
    coord_t [2:0]      bmax;
    logic [2:0]        neg;
    logic              zero;
    logic [2:0][29:0]  nmag;
  } geo_t;

  // data that rides along the slab divider chain
  typedef struct packed {
    coord_t [2:0]      o;
    logic [2:0][30:0]  dmag;
    logic [2:0]        dneg;
    logic [2:0]        par;
    logic [5:0]        nneg;
    logic              pfail;
  } slab_t;

endpackage

>>> rtl/rbs_sqrt_cell.sv
`timescale 1ns / 1ps
// rbs_sqrt_cell: one registered step of the bitwise integer square root.
// Depends on rbs_pkg.
module rbs_sqrt_cell (
  input  logic                clk,
  input  logic                en,
  input  logic [62:0]         bit_val,
  input  rbs_pkg::sqrt_lane_t lane_in,
  output rbs_pkg::sqrt_lane_t lane_out
);

  logic [62:0] trial;
  logic        take;
  rbs_pkg::sqrt_lane_t lane_next;

  always_comb begin
    trial = lane_in.r + bit_val;
    take  = lane_in.x >= trial;
    if (take) begin
      lane_next.x = lane_in.x - trial;
      lane_next.r = (lane_in.r >> 1) + bit_val;
    end else begin
      lane_next.x = lane_in.x;
      lane_next.r = lane_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

>>> rtl/rbs_div_cell.sv
`timescale 1ns / 1ps
// rbs_div_cell: one registered step of an unsigned restoring divider
// (one quotient bit per cell). Depends on rbs_pkg.
module rbs_div_cell (
  input  logic               clk,
  input  logic               en,
  input  rbs_pkg::div_lane_t lane_in,
  output rbs_pkg::div_lane_t lane_out
);

  logic [31:0] shifted;
  logic [31:0] diff;
  logic        take;
  rbs_pkg::div_lane_t lane_next;

  always_comb begin
    shifted        = {lane_in.rem, lane_in.num[52]};
    diff           = shifted - {1'b0, lane_in.den};
    take           = shifted >= {1'b0, lane_in.den};
    lane_next.rem  = take ? diff[30:0] : shifted[30:0];
    lane_next.den  = lane_in.den;
    lane_next.num  = {lane_in.num[51:0], 1'b0};
    lane_next.quo  = {lane_in.quo[51:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

>>> rtl/ray_box_slab_intersect_core.sv
`timescale 1ns / 1ps
// ray_box_slab_intersect_core: pipelined fixed-point ray vs. box slab test.
// Depends on rbs_pkg, rbs_sqrt_cell, rbs_div_cell.
//
//  channel | signals                          | dir | moves
//  cfg     | cfg_valid cfg_ready cfg_data     | in  | max_distance write
//  in      | in_valid in_ready ray_*/box_*    | in  | one query request
//  out     | out_valid out_ready hit hit_*    | out | one result
//
// One request per cycle while the output is not stalled; the pipe holds 5 setup stages, 32 root cells,
// 1 + 31 direction divider cells, 1 + 53 slab divider cells, 4 finish stages.
// The slab divider chain (one quotient bit per cell) sets the latency.
// A stalled result freezes the whole pipe; in_ready = !out_valid | out_ready.
// rst (synchronous) clears all valid bits and loads max_distance = 20000.0.
module ray_box_slab_intersect_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [30:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  ray_start_x,
  input  logic signed [31:0]  ray_start_y,
  input  logic signed [31:0]  ray_start_z,
  input  logic signed [31:0]  ray_end_x,
  input  logic signed [31:0]  ray_end_y,
  input  logic signed [31:0]  ray_end_z,
  input  logic signed [31:0]  box_min_x,
  input  logic signed [31:0]  box_min_y,
  input  logic signed [31:0]  box_min_z,
  input  logic signed [31:0]  box_max_x,
  input  logic signed [31:0]  box_max_y,
  input  logic signed [31:0]  box_max_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic signed [31:0]  hit_x,
  output logic signed [31:0]  hit_y,
  output logic signed [31:0]  hit_z
);

  logic        adv;
  logic [30:0] max_distance;

  rbs_pkg::coord_t s_in [3];
  rbs_pkg::coord_t e_in [3];
  rbs_pkg::coord_t mn_in [3];
  rbs_pkg::coord_t mx_in [3];

  assign s_in[0]  = ray_start_x;
  assign s_in[1]  = ray_start_y;
  assign s_in[2]  = ray_start_z;
  assign e_in[0]  = ray_end_x;
  assign e_in[1]  = ray_end_y;
  assign e_in[2]  = ray_end_z;
  assign mn_in[0] = box_min_x;
  assign mn_in[1] = box_min_y;
  assign mn_in[2] = box_min_z;
  assign mx_in[0] = box_max_x;
  assign mx_in[1] = box_max_y;
  assign mx_in[2] = box_max_z;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= rbs_pkg::MAXD_RESET;
    end else if (cfg_valid) begin
      max_distance <= cfg_data;
    end
  end

  // stage A: deltas
  logic                va;
  rbs_pkg::coord_t     a_o [3];
  rbs_pkg::coord_t     a_mn [3];
  rbs_pkg::coord_t     a_mx [3];
  logic signed [32:0]  a_dlt [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_o[i]   <= s_in[i];
        a_mn[i]  <= mn_in[i];
        a_mx[i]  <= mx_in[i];
        a_dlt[i] <= $signed({e_in[i][31], e_in[i]}) - $signed({s_in[i][31], s_in[i]});
      end
    end
  end

  // stage B: magnitudes
  logic              vb;
  rbs_pkg::coord_t   b_o [3];
  rbs_pkg::coord_t   b_mn [3];
  rbs_pkg::coord_t   b_mx [3];
  logic [32:0]       b_mag [3];
  logic [2:0]        b_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_o[i]   <= a_o[i];
        b_mn[i]  <= a_mn[i];
        b_mx[i]  <= a_mx[i];
        b_neg[i] <= a_dlt[i][32];
        b_mag[i] <= a_dlt[i][32] ? 33'(-a_dlt[i]) : 33'(a_dlt[i]);
      end
    end
  end

  // stage C: common normalizing shift, top bit of largest magnitude at 29
  logic          vc;
  rbs_pkg::geo_t c_geo;
  logic [32:0]   orv;
  logic [5:0]    msb;
  logic [32:0]   nm [3];

  always_comb begin
    orv = b_mag[0] | b_mag[1] | b_mag[2];
    msb = '0;
    for (int b = 0; b < 33; b++) begin
      if (orv[b]) begin
        msb = 6'(b);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (msb >= 6'd30) begin
        nm[i] = b_mag[i] >> (msb - 6'd29);
      end else begin
        nm[i] = b_mag[i] << (6'd29 - msb);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_geo.o[i]    <= b_o[i];
        c_geo.bmin[i] <= b_mn[i];
        c_geo.bmax[i] <= b_mx[i];
        c_geo.nmag[i] <= nm[i][29:0];
      end
      c_geo.neg  <= b_neg;
      c_geo.zero <= (orv == '0);
    end
  end

  // stage D: squares
  logic          vdq;
  rbs_pkg::geo_t d_geo;
  logic [59:0]   d_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vdq <= 1'b0;
    end else if (adv) begin
      vdq <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_geo <= c_geo;
      for (int i = 0; i < 3; i++) begin
        d_sq[i] <= 60'(c_geo.nmag[i]) * 60'(c_geo.nmag[i]);
      end
    end
  end

  // stage E: sum of squares, head of the root chain
  rbs_pkg::sqrt_lane_t sq_head;
  rbs_pkg::sqrt_lane_t sq_lane [rbs_pkg::SQRT_STEPS];
  rbs_pkg::geo_t       geo_s [rbs_pkg::SQRT_STEPS+1];
  logic                vs [rbs_pkg::SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= rbs_pkg::SQRT_STEPS; k++) begin
        vs[k] <= 1'b0;
      end
    end else if (adv) begin
      vs[0] <= vdq;
      for (int k = 0; k < rbs_pkg::SQRT_STEPS; k++) begin
        vs[k+1] <= vs[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_head.x <= 63'(d_sq[0]) + 63'(d_sq[1]) + 63'(d_sq[2]);
      sq_head.r <= '0;
      geo_s[0]  <= d_geo;
      for (int k = 0; k < rbs_pkg::SQRT_STEPS; k++) begin
        geo_s[k+1] <= geo_s[k];
      end
    end
  end

  for (genvar k = 0; k < rbs_pkg::SQRT_STEPS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      rbs_sqrt_cell u_cell (
        .clk      (clk),
        .en       (adv),
        .bit_val  (63'(1) << (62 - 2 * k)),
        .lane_in  (sq_head),
        .lane_out (sq_lane[k])
      );
    end else begin : g_rest
      rbs_sqrt_cell u_cell (
        .clk      (clk),
        .en       (adv),
        .bit_val  (63'(1) << (62 - 2 * k)),
        .lane_in  (sq_lane[k-1]),
        .lane_out (sq_lane[k])
      );
    end
  end

  // direction divider: |d| = nmag * 2^30 / len
  rbs_pkg::div_lane_t dd_head [3];
  rbs_pkg::div_lane_t dd_lane [rbs_pkg::DIR_STEPS][3];
  rbs_pkg::geo_t      geo_d [rbs_pkg::DIR_STEPS+1];
  logic               vd [rbs_pkg::DIR_STEPS+1];
  logic [30:0]        len;

  assign len = sq_lane[rbs_pkg::SQRT_STEPS-1].r[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= rbs_pkg::DIR_STEPS; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (adv) begin
      vd[0] <= vs[rbs_pkg::SQRT_STEPS];
      for (int k = 0; k < rbs_pkg::DIR_STEPS; k++) begin
        vd[k+1] <= vd[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_d[0] <= geo_s[rbs_pkg::SQRT_STEPS];
      for (int i = 0; i < 3; i++) begin
        dd_head[i].rem <= {2'b0, geo_s[rbs_pkg::SQRT_STEPS].nmag[i][29:1]};
        dd_head[i].den <= len;
        dd_head[i].num <= {geo_s[rbs_pkg::SQRT_STEPS].nmag[i][0], 52'b0};
        dd_head[i].quo <= '0;
      end
      for (int k = 0; k < rbs_pkg::DIR_STEPS; k++) begin
        geo_d[k+1] <= geo_d[k];
      end
    end
  end

  for (genvar k = 0; k < rbs_pkg::DIR_STEPS; k++) begin : g_dir
    for (genvar i = 0; i < rbs_pkg::LANES; i++) begin : g_lane
      if (k == 0) begin : g_first
        rbs_div_cell u_cell (
          .clk      (clk),
          .en       (adv),
          .lane_in  (dd_head[i]),
          .lane_out (dd_lane[k][i])
        );
      end else begin : g_rest
        rbs_div_cell u_cell (
          .clk      (clk),
          .en       (adv),
          .lane_in  (dd_lane[k-1][i]),
          .lane_out (dd_lane[k][i])
        );
      end
    end
  end

  // stage F: direction, parallel checks, slab numerators
  rbs_pkg::geo_t      gf;
  logic [30:0]        cdir [3];
  logic [2:0]         par;
  logic               pfail;
  logic signed [32:0] nb [6];
  logic [31:0]        nabs [6];

  assign gf = geo_d[rbs_pkg::DIR_STEPS];

  always_comb begin
    pfail = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cdir[i] = gf.zero ? '0 : dd_lane[rbs_pkg::DIR_STEPS-1][i].quo[30:0];
      par[i]  = cdir[i] < rbs_pkg::PAR_EPS;
      if (par[i] && (($signed(gf.o[i]) < $signed(gf.bmin[i])) ||
                     ($signed(gf.o[i]) > $signed(gf.bmax[i])))) begin
        pfail = 1'b1;
      end
      nb[2*i]   = $signed({gf.bmin[i][31], gf.bmin[i]}) - $signed({gf.o[i][31], gf.o[i]});
      nb[2*i+1] = $signed({gf.bmax[i][31], gf.bmax[i]}) - $signed({gf.o[i][31], gf.o[i]});
    end
    for (int j = 0; j < 6; j++) begin
      nabs[j] = nb[j][32] ? 32'(-nb[j]) : 32'(nb[j]);
    end
  end

  rbs_pkg::div_lane_t sl_head [6];
  rbs_pkg::div_lane_t sl_lane [rbs_pkg::SLAB_STEPS][6];
  rbs_pkg::slab_t     sd [rbs_pkg::SLAB_STEPS+1];
  logic               vl [rbs_pkg::SLAB_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= rbs_pkg::SLAB_STEPS; k++) begin
        vl[k] <= 1'b0;
      end
    end else if (adv) begin
      vl[0] <= vd[rbs_pkg::DIR_STEPS];
      for (int k = 0; k < rbs_pkg::SLAB_STEPS; k++) begin
        vl[k+1] <= vl[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sd[0].o[i]    <= gf.o[i];
        sd[0].dmag[i] <= cdir[i];
      end
      sd[0].dneg  <= gf.neg & {3{!gf.zero}};
      sd[0].par   <= par;
      sd[0].pfail <= pfail;
      for (int j = 0; j < 6; j++) begin
        sd[0].nneg[j]  <= nb[j][32];
        sl_head[j].rem <= {22'b0, nabs[j][31:23]};
        sl_head[j].den <= cdir[j/2];
        sl_head[j].num <= {nabs[j][22:0], 30'b0};
        sl_head[j].quo <= '0;
      end
      for (int k = 0; k < rbs_pkg::SLAB_STEPS; k++) begin
        sd[k+1] <= sd[k];
      end
    end
  end

  for (genvar k = 0; k < rbs_pkg::SLAB_STEPS; k++) begin : g_slab
    for (genvar j = 0; j < rbs_pkg::SLAB_LANES; j++) begin : g_lane
      if (k == 0) begin : g_first
        rbs_div_cell u_cell (
          .clk      (clk),
          .en       (adv),
          .lane_in  (sl_head[j]),
          .lane_out (sl_lane[k][j])
        );
      end else begin : g_rest
        rbs_div_cell u_cell (
          .clk      (clk),
          .en       (adv),
          .lane_in  (sl_lane[k-1][j]),
          .lane_out (sl_lane[k][j])
        );
      end
    end
  end

  // stage G: signed slab parameters, ordered per axis
  rbs_pkg::slab_t     sg;
  logic signed [53:0] tv [6];
  logic               vg;
  rbs_pkg::slab_t     g_side;
  logic signed [53:0] g_lo [3];
  logic signed [53:0] g_hi [3];

  assign sg = sd[rbs_pkg::SLAB_STEPS];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      if (sg.nneg[j] ^ sg.dneg[j/2]) begin
        tv[j] = -$signed({1'b0, sl_lane[rbs_pkg::SLAB_STEPS-1][j].quo});
      end else begin
        tv[j] = $signed({1'b0, sl_lane[rbs_pkg::SLAB_STEPS-1][j].quo});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (adv) begin
      vg <= vl[rbs_pkg::SLAB_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_side <= sg;
      for (int i = 0; i < 3; i++) begin
        if (tv[2*i] > tv[2*i+1]) begin
          g_lo[i] <= tv[2*i+1];
          g_hi[i] <= tv[2*i];
        end else begin
          g_lo[i] <= tv[2*i];
          g_hi[i] <= tv[2*i+1];
        end
      end
    end
  end

  // stage H: interval and hit decision
  logic signed [53:0] tmn;
  logic signed [53:0] tmx;
  logic               vh;
  logic               h_hit;
  logic [30:0]        h_tmin;
  rbs_pkg::slab_t     h_side;

  always_comb begin
    tmn = '0;
    tmx = $signed({23'b0, max_distance});
    for (int i = 0; i < 3; i++) begin
      if (!g_side.par[i]) begin
        if (g_lo[i] > tmn) begin
          tmn = g_lo[i];
        end
        if (g_hi[i] < tmx) begin
          tmx = g_hi[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else if (adv) begin
      vh <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_side <= g_side;
      h_hit  <= !g_side.pfail && (tmn <= tmx);
      h_tmin <= tmn[30:0];
    end
  end

  // stage I: offsets
  logic           vi;
  logic           i_hit;
  rbs_pkg::slab_t i_side;
  logic [61:0]    i_prod [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vi <= 1'b0;
    end else if (adv) begin
      vi <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_side <= h_side;
      i_hit  <= h_hit;
      for (int i = 0; i < 3; i++) begin
        i_prod[i] <= 62'(h_side.dmag[i]) * 62'(h_tmin);
      end
    end
  end

  // stage J: hit point, saturated, into the output register
  logic [31:0]        off [3];
  logic signed [33:0] sum [3];
  rbs_pkg::coord_t    pt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = i_prod[i][61:30];
      if (i_side.dneg[i]) begin
        sum[i] = $signed({{2{i_side.o[i][31]}}, i_side.o[i]}) - $signed({2'b0, off[i]});
      end else begin
        sum[i] = $signed({{2{i_side.o[i][31]}}, i_side.o[i]}) + $signed({2'b0, off[i]});
      end
      if (!i_hit) begin
        pt[i] = '0;
      end else if (sum[i] > 34'sd2147483647) begin
        pt[i] = 32'sh7FFFFFFF;
      end else if (sum[i] < -34'sd2147483648) begin
        pt[i] = 32'sh80000000;
      end else begin
        pt[i] = sum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit   <= i_hit;
      hit_x <= pt[0];
      hit_y <= pt[1];
      hit_z <= pt[2];
    end
  end

endmodule

>>> rtl/rbs_chk.sv
`timescale 1ns / 1ps
// rbs_chk: port-level checks for ray_box_slab_intersect_core, bound to it below.
// Depends on ray_box_slab_intersect_core's port list only.
module rbs_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               hit,
  input logic signed [31:0] hit_x,
  input logic signed [31:0] hit_y,
  input logic signed [31:0] hit_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(hit) && $stable(hit_x) &&
                                $stable(hit_y) && $stable(hit_z))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_x == 32'sd0 && hit_y == 32'sd0 && hit_z == 32'sd0)
    else $error("miss with nonzero point");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while pipe stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_box_slab_intersect_core rbs_chk u_rbs_chk (.*);
